// File: hw/rtl/bmr_pkg.sv
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types, codes and constants of the banked mapper with RTC.
// ----------------------------------------------------------------------------
package bmr_pkg;

  localparam int RAM_BANK_COUNT_DEF = 4;
  localparam int ROM_BANK_WIDTH_DEF = 7;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] TGT_DATA   = 3'd0;
  localparam logic [2:0] TGT_ROM_RD = 3'd1;
  localparam logic [2:0] TGT_RAM_RD = 3'd2;
  localparam logic [2:0] TGT_RAM_WR = 3'd3;
  localparam logic [2:0] TGT_NONE   = 3'd4;

  localparam logic [2:0] RTC_SEC  = 3'd0;
  localparam logic [2:0] RTC_MIN  = 3'd1;
  localparam logic [2:0] RTC_HOUR = 3'd2;
  localparam logic [2:0] RTC_DAYL = 3'd3;
  localparam logic [2:0] RTC_DAYH = 3'd4;

  localparam logic REG_ROM_BANK_BITS = 1'b0;
  localparam logic REG_RAM_BANKS     = 1'b1;

  localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
  localparam logic [7:0] OPEN_BUS       = 8'hFF;
  localparam logic [7:0] SEC_MAX        = 8'h3B;
  localparam logic [7:0] HOUR_MAX       = 8'h17;
  localparam int         HALT_BIT       = 6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [20:0] mapped_addr;
    logic [7:0]  read_data;
    logic [7:0]  ram_wdata;
  } result_t;

  typedef struct packed {
    logic       tick;
    logic       wr;
    logic       latch;
    logic [2:0] idx;
    logic [7:0] data;
  } rtc_ctl_t;

  typedef struct packed {
    logic [2:0] rom_bank_bits;
    logic [2:0] ram_banks;
  } cfg_t;

endpackage

// File: hw/rtl/bmr_cfg.sv
// ----------------------------------------------------------------------------
// bmr_cfg
// APB configuration registers: ROM bank bits and RAM bank count.
// ----------------------------------------------------------------------------
module bmr_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bmr_pkg::cfg_t       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rom_bank_bits <= 3'd7;
      cfg.ram_banks     <= 3'd4;
    end else if (wr_en) begin
      if (paddr[2] == bmr_pkg::REG_ROM_BANK_BITS) begin
        cfg.rom_bank_bits <= pwdata[2:0];
      end else begin
        cfg.ram_banks <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == bmr_pkg::REG_RAM_BANKS) begin
      prdata = {29'd0, cfg.ram_banks};
    end else begin
      prdata = {29'd0, cfg.rom_bank_bits};
    end
  end

endmodule

// File: hw/rtl/bmr_rtc.sv
// ----------------------------------------------------------------------------
// bmr_rtc
// Real-time clock: register file, halt flag, elapsed-time counter kept in
// seconds/minutes/hours digits, and the latch fold.
// ----------------------------------------------------------------------------
module bmr_rtc (
  input  logic                clk,
  input  logic                rst,
  input  bmr_pkg::rtc_ctl_t   ctl,
  output logic [7:0]          rd
);

  logic [7:0] rtc_regs [5];
  logic       halted;
  logic [5:0] el_sec;
  logic [5:0] el_min;
  logic [4:0] el_hour;

  logic [6:0] sec_sum;
  logic [6:0] min_sum;
  logic [5:0] hour_sum;
  logic       sec_cy;
  logic       min_cy;
  logic [7:0] sec_fold;
  logic [7:0] min_fold;
  logic [7:0] hour_fold;
  logic [7:0] clamp60;
  logic [7:0] clamp24;

  // latch fold, digit by digit with carry
  always_comb begin
    sec_sum   = 7'(rtc_regs[0]) + 7'(el_sec);
    sec_cy    = sec_sum >= 7'd60;
    sec_fold  = 8'(sec_cy ? sec_sum - 7'd60 : sec_sum);
    min_sum   = 7'(rtc_regs[1]) + 7'(el_min) + 7'(sec_cy);
    min_cy    = min_sum >= 7'd60;
    min_fold  = 8'(min_cy ? min_sum - 7'd60 : min_sum);
    hour_sum  = 6'(rtc_regs[2]) + 6'(el_hour) + 6'(min_cy);
    hour_fold = 8'(hour_sum >= 6'd24 ? hour_sum - 6'd24 : hour_sum);
    clamp60   = (ctl.data > bmr_pkg::SEC_MAX) ? bmr_pkg::SEC_MAX : ctl.data;
    clamp24   = (ctl.data > bmr_pkg::HOUR_MAX) ? bmr_pkg::HOUR_MAX : ctl.data;
  end

  always_comb begin
    unique case (ctl.idx)
      bmr_pkg::RTC_SEC:  rd = rtc_regs[0];
      bmr_pkg::RTC_MIN:  rd = rtc_regs[1];
      bmr_pkg::RTC_HOUR: rd = rtc_regs[2];
      bmr_pkg::RTC_DAYL: rd = rtc_regs[3];
      bmr_pkg::RTC_DAYH: rd = rtc_regs[4];
      default:           rd = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        rtc_regs[i] <= 8'd0;
      end
      halted  <= 1'b0;
      el_sec  <= 6'd0;
      el_min  <= 6'd0;
      el_hour <= 5'd0;
    end else if (ctl.tick) begin
      if (!halted) begin
        if (el_sec != 6'd59) begin
          el_sec <= el_sec + 6'd1;
        end else begin
          el_sec <= 6'd0;
          if (el_min != 6'd59) begin
            el_min <= el_min + 6'd1;
          end else begin
            el_min  <= 6'd0;
            el_hour <= (el_hour == 5'd23) ? 5'd0 : el_hour + 5'd1;
          end
        end
      end
    end else if (ctl.wr) begin
      el_sec  <= 6'd0;
      el_min  <= 6'd0;
      el_hour <= 5'd0;
      unique case (ctl.idx)
        bmr_pkg::RTC_SEC:  rtc_regs[0] <= clamp60;
        bmr_pkg::RTC_MIN:  rtc_regs[1] <= clamp60;
        bmr_pkg::RTC_HOUR: rtc_regs[2] <= clamp24;
        bmr_pkg::RTC_DAYL: rtc_regs[3] <= ctl.data;
        bmr_pkg::RTC_DAYH: begin
          halted      <= ctl.data[bmr_pkg::HALT_BIT];
          rtc_regs[4] <= ctl.data & (8'd1 << bmr_pkg::HALT_BIT);
        end
        default: ;
      endcase
    end else if (ctl.latch && !halted) begin
      rtc_regs[0] <= sec_fold;
      rtc_regs[1] <= min_fold;
      rtc_regs[2] <= hour_fold;
      rtc_regs[3] <= 8'd0;
      rtc_regs[4] <= 8'd0;
      el_sec      <= 6'd0;
      el_min      <= 6'd0;
      el_hour     <= 5'd0;
    end
  end

  a_sec_min_range: assert property (@(posedge clk) disable iff (rst)
    rtc_regs[0] <= bmr_pkg::SEC_MAX && rtc_regs[1] <= bmr_pkg::SEC_MAX)
    else $error("rtc seconds/minutes out of range");

  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    rtc_regs[2] <= bmr_pkg::HOUR_MAX)
    else $error("rtc hours out of range");

  a_elapsed_range: assert property (@(posedge clk) disable iff (rst)
    el_sec <= 6'd59 && el_min <= 6'd59 && el_hour <= 5'd23)
    else $error("elapsed counter out of range");

endmodule

// File: hw/rtl/bmr_core.sv
// ----------------------------------------------------------------------------
// bmr_core
// Bus decode and banking state: maps reads and writes to targets and
// addresses, updates bank registers and drives the RTC controls.
// ----------------------------------------------------------------------------
module bmr_core #(
  parameter int RAM_BANK_COUNT = bmr_pkg::RAM_BANK_COUNT_DEF,
  parameter int ROM_BANK_WIDTH = bmr_pkg::ROM_BANK_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  bmr_pkg::item_t      item,
  input  bmr_pkg::cfg_t       cfg,
  input  logic [7:0]          rtc_rd,
  output bmr_pkg::rtc_ctl_t   rtc_ctl,
  output bmr_pkg::result_t    result
);

  logic [ROM_BANK_WIDTH-1:0] rom_bank, rom_bank_next;
  logic [1:0]                ram_bank, ram_bank_next;
  logic                      ram_enabled, ram_enabled_next;
  logic                      maps_ram, maps_ram_next;
  logic [2:0]                rtc_index, rtc_index_next;
  logic                      latch_armed, latch_armed_next;

  logic [6:0]  bank_raw;
  logic [1:0]  bank_mod;
  logic        in_ext;
  logic [20:0] rom_addr;
  logic [20:0] ram_addr;

  always_comb begin
    bank_raw = item.wdata[6:0];
    if (bank_raw == 7'd0) begin
      bank_raw = 7'd1;
    end
    for (int i = 0; i < ROM_BANK_WIDTH; i++) begin
      rom_bank_next[i] = bank_raw[i] && (i < int'(cfg.rom_bank_bits));
    end
    bank_mod = item.wdata[1:0];
    for (int k = 0; k < 3; k++) begin
      if (int'(bank_mod) >= RAM_BANK_COUNT) begin
        bank_mod = bank_mod - 2'(RAM_BANK_COUNT);
      end
    end
  end

  assign in_ext   = item.addr[15:13] == 3'b101;
  assign rom_addr = 21'(item.addr[13:0]) | (21'(rom_bank) << 14);
  assign ram_addr = 21'(item.addr[12:0]) | (21'(ram_bank) << 13);

  always_comb begin
    ram_bank_next    = ram_bank;
    ram_enabled_next = ram_enabled;
    maps_ram_next    = maps_ram;
    rtc_index_next   = rtc_index;
    latch_armed_next = latch_armed;
    result.target      = bmr_pkg::TGT_NONE;
    result.mapped_addr = 21'd0;
    result.read_data   = 8'd0;
    result.ram_wdata   = 8'd0;
    rtc_ctl.tick  = 1'b0;
    rtc_ctl.wr    = 1'b0;
    rtc_ctl.latch = 1'b0;
    rtc_ctl.idx   = rtc_index;
    rtc_ctl.data  = item.wdata;

    unique case (item.cmd)
      bmr_pkg::CMD_READ: begin
        result.target = bmr_pkg::TGT_DATA;
        if (!item.addr[15]) begin
          result.target      = bmr_pkg::TGT_ROM_RD;
          result.mapped_addr = item.addr[14] ? rom_addr : 21'(item.addr[13:0]);
        end else if (in_ext) begin
          if (!ram_enabled) begin
            result.read_data = bmr_pkg::OPEN_BUS;
          end else if (maps_ram) begin
            if (cfg.ram_banks != 3'd0) begin
              result.target      = bmr_pkg::TGT_RAM_RD;
              result.mapped_addr = ram_addr;
            end
          end else begin
            result.read_data = rtc_rd;
          end
        end
      end
      bmr_pkg::CMD_WRITE: begin
        if (!item.addr[15]) begin
          unique case (item.addr[14:13])
            2'd0: begin
              if (item.wdata == bmr_pkg::RAM_ENABLE_KEY) begin
                ram_enabled_next = 1'b1;
              end else if (item.wdata == 8'd0) begin
                ram_enabled_next = 1'b0;
              end
            end
            2'd1: ;
            2'd2: begin
              if (item.wdata <= 8'd3) begin
                maps_ram_next = 1'b1;
                ram_bank_next = bank_mod;
              end else if (item.wdata >= 8'h08 && item.wdata <= 8'h0C) begin
                maps_ram_next  = 1'b0;
                rtc_index_next = item.wdata[2:0];
              end
            end
            default: begin
              rtc_ctl.latch    = en && item.wdata == 8'd1 && latch_armed;
              latch_armed_next = item.wdata == 8'd0;
            end
          endcase
        end else if (in_ext) begin
          if (maps_ram) begin
            if (cfg.ram_banks != 3'd0) begin
              result.target      = bmr_pkg::TGT_RAM_WR;
              result.mapped_addr = ram_addr;
              result.ram_wdata   = item.wdata;
            end
          end else begin
            rtc_ctl.wr = en;
          end
        end
      end
      bmr_pkg::CMD_TICK: rtc_ctl.tick = en;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank    <= ROM_BANK_WIDTH'(1);
      ram_bank    <= 2'd0;
      ram_enabled <= 1'b0;
      maps_ram    <= 1'b0;
      rtc_index   <= bmr_pkg::RTC_SEC;
      latch_armed <= 1'b1;
    end else if (en) begin
      if (item.cmd == bmr_pkg::CMD_WRITE && item.addr[15:13] == 3'b001) begin
        rom_bank <= rom_bank_next;
      end
      ram_bank    <= ram_bank_next;
      ram_enabled <= ram_enabled_next;
      maps_ram    <= maps_ram_next;
      rtc_index   <= rtc_index_next;
      latch_armed <= latch_armed_next;
    end
  end

  a_rtc_index_range: assert property (@(posedge clk) disable iff (rst)
    rtc_index <= bmr_pkg::RTC_DAYH)
    else $error("rtc select out of range");

  a_ram_bank_range: assert property (@(posedge clk) disable iff (rst)
    int'(ram_bank) < RAM_BANK_COUNT)
    else $error("ram bank beyond bank count");

  a_rtc_one_op: assert property (@(posedge clk) disable iff (rst)
    $countones({rtc_ctl.tick, rtc_ctl.wr, rtc_ctl.latch}) <= 1)
    else $error("more than one rtc operation per transaction");

endmodule

// File: hw/rtl/banked_mapper_with_rtc_unit.sv
// ----------------------------------------------------------------------------
// banked_mapper_with_rtc_unit
// Cartridge bank mapper with real-time clock: input register, decode and
// state update, result register.
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tuser cmd, tdata addr, wdata
//   m_axis    out  tvalid/tready         tuser target, tdata addresses/data
//   apb       in   psel/penable/pready   rom_bank_bits @0x0, ram_banks @0x4
//
// One transaction per cycle unless m_axis stalls.
// All decode, bank and RTC updates happen in the single cycle that moves a
// transaction from the input register to the result register.
// Reset is synchronous; both registers come up empty.
// A stalled m_axis holds the result; the input register fills, then
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module banked_mapper_with_rtc_unit #(
  parameter int RAM_BANK_COUNT = bmr_pkg::RAM_BANK_COUNT_DEF,
  parameter int ROM_BANK_WIDTH = bmr_pkg::ROM_BANK_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // addr[15:0], wdata[23:16]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // mapped_addr[20:0], read_data[28:21],
                                      // ram_wdata[36:29], zero[39:37]
  output logic [2:0]  m_axis_tuser,   // target[2:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bmr_pkg::cfg_t     cfg;
  bmr_pkg::item_t    in_item;
  bmr_pkg::result_t  res_comb;
  bmr_pkg::result_t  res;
  bmr_pkg::rtc_ctl_t rtc_ctl;
  logic [7:0]        rtc_rd;
  logic              in_valid;
  logic              advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.cmd   <= s_axis_tuser;
      in_item.addr  <= s_axis_tdata[15:0];
      in_item.wdata <= s_axis_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign m_axis_tuser = res.target;
  assign m_axis_tdata = {3'd0, res.ram_wdata, res.read_data, res.mapped_addr};

  bmr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmr_core #(
    .RAM_BANK_COUNT (RAM_BANK_COUNT),
    .ROM_BANK_WIDTH (ROM_BANK_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .item    (in_item),
    .cfg     (cfg),
    .rtc_rd  (rtc_rd),
    .rtc_ctl (rtc_ctl),
    .result  (res_comb)
  );

  bmr_rtc u_rtc (
    .clk (clk),
    .rst (rst),
    .ctl (rtc_ctl),
    .rd  (rtc_rd)
  );

  a_rdata_only_for_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != bmr_pkg::TGT_DATA |-> m_axis_tdata[28:21] == 8'd0)
    else $error("read data on non-data target");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == bmr_pkg::TGT_DATA || m_axis_tuser == bmr_pkg::TGT_NONE)
    |-> m_axis_tdata[20:0] == 21'd0)
    else $error("mapped address on unmapped target");

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |-> !s_axis_tready)
    else $error("input accepted while input register is held");

endmodule

// File: tb/sv/tb_banked_mapper_with_rtc_unit.sv
// ----------------------------------------------------------------------------
// tb_banked_mapper_with_rtc_unit
// Self-checking bench for the banked mapper with real-time clock. A
// transaction-level predictor tracks bank, enable and clock state and forms
// the expected result of every transaction on the input stream. The bench
// drives directed ROM, RAM, RTC, latch and unmapped cases, a clock fold
// across midnight, and random traffic under several register settings. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_banked_mapper_with_rtc_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          IDLE_LIMIT  = 4000;
  localparam int          SETTLE      = 4;
  localparam int unsigned DAY_SECONDS = 86400;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // addr[15:0], wdata[23:16]
  logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // mapped_addr[20:0], read_data[28:21],
                                    // ram_wdata[36:29], zero[39:37]
  logic [2:0]  m_axis_tuser;        // target[2:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  banked_mapper_with_rtc_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mapper state as predicted
  logic [2:0]  cfg_rom_bits;
  logic [2:0]  cfg_ram_banks;
  logic [6:0]  bank_rom;
  logic [1:0]  bank_ram;
  logic        ram_on;
  logic        ram_mapped;
  logic [2:0]  rtc_sel;
  logic [7:0]  rtc_reg [5];
  logic        halted;
  logic        latch_ready;
  logic [16:0] tick_count;

  bmr_pkg::result_t expected_results [$];
  int      error_count = 0;
  int      items_sent = 0;
  int      burst_left = 0;
  int      stall_left = 0;
  int      stall_mode = 0;
  bit      no_idle = 1'b0;

  function automatic void reset_mapper_state();
    cfg_rom_bits  = 3'd7;
    cfg_ram_banks = 3'd4;
    bank_rom      = 7'd1;
    bank_ram      = '0;
    ram_on        = 1'b0;
    ram_mapped    = 1'b0;
    rtc_sel       = bmr_pkg::RTC_SEC;
    foreach (rtc_reg[i]) rtc_reg[i] = '0;
    halted        = 1'b0;
    latch_ready   = 1'b1;
    tick_count    = '0;
  endfunction

  function automatic void latch_clock();
    int unsigned total;
    if (halted) return;
    total = rtc_reg[bmr_pkg::RTC_SEC] + rtc_reg[bmr_pkg::RTC_MIN] * 60
          + rtc_reg[bmr_pkg::RTC_HOUR] * 3600 + tick_count;
    rtc_reg[bmr_pkg::RTC_SEC]  = 8'(total % 60);
    rtc_reg[bmr_pkg::RTC_MIN]  = 8'((total / 60) % 60);
    rtc_reg[bmr_pkg::RTC_HOUR] = 8'((total / 3600) % 24);
    rtc_reg[bmr_pkg::RTC_DAYL] = '0;
    rtc_reg[bmr_pkg::RTC_DAYH] = '0;
    tick_count = '0;
  endfunction

  function automatic void write_clock_reg(logic [7:0] d);
    tick_count = '0;
    case (rtc_sel)
      bmr_pkg::RTC_SEC, bmr_pkg::RTC_MIN:
        rtc_reg[rtc_sel] = (d > bmr_pkg::SEC_MAX) ? bmr_pkg::SEC_MAX : d;
      bmr_pkg::RTC_HOUR:
        rtc_reg[rtc_sel] = (d > bmr_pkg::HOUR_MAX) ? bmr_pkg::HOUR_MAX : d;
      bmr_pkg::RTC_DAYL:
        rtc_reg[rtc_sel] = d;
      default: begin
        halted = d[bmr_pkg::HALT_BIT];
        rtc_reg[bmr_pkg::RTC_DAYH] = d & (8'd1 << bmr_pkg::HALT_BIT);
      end
    endcase
  endfunction

  function automatic bmr_pkg::result_t predict_access(bmr_pkg::item_t it);
    bmr_pkg::result_t r;
    logic [7:0]       d;
    int unsigned      b;
    r = '0;
    r.target = bmr_pkg::TGT_NONE;
    d = it.wdata;
    case (it.cmd)
      bmr_pkg::CMD_READ: begin
        r.target = bmr_pkg::TGT_DATA;
        if (it.addr < 16'h4000) begin
          r.target = bmr_pkg::TGT_ROM_RD;
          r.mapped_addr = 21'(it.addr);
        end else if (it.addr < 16'h8000) begin
          r.target = bmr_pkg::TGT_ROM_RD;
          r.mapped_addr = {bank_rom, it.addr[13:0]};
        end else if (it.addr >= 16'hA000 && it.addr < 16'hC000) begin
          if (!ram_on) begin
            r.read_data = bmr_pkg::OPEN_BUS;
          end else if (ram_mapped) begin
            if (cfg_ram_banks != 0) begin
              r.target = bmr_pkg::TGT_RAM_RD;
              r.mapped_addr = 21'({bank_ram, it.addr[12:0]});
            end
          end else begin
            r.read_data = rtc_reg[rtc_sel];
          end
        end
      end
      bmr_pkg::CMD_WRITE: begin
        if (it.addr < 16'h2000) begin
          if (d == bmr_pkg::RAM_ENABLE_KEY) ram_on = 1'b1;
          else if (d == 8'h00) ram_on = 1'b0;
        end else if (it.addr < 16'h4000) begin
          b = d & 8'h7F;
          if (b == 0) b = 1;
          b = b & ((1 << cfg_rom_bits) - 1);
          bank_rom = b[6:0];
        end else if (it.addr < 16'h6000) begin
          if (d <= 8'd3) begin
            ram_mapped = 1'b1;
            bank_ram = 2'((d % bmr_pkg::RAM_BANK_COUNT_DEF) & 3);
          end else if (d >= 8'h08 && d <= 8'h0C) begin
            ram_mapped = 1'b0;
            rtc_sel = 3'(d - 8'h08);
          end
        end else if (it.addr < 16'h8000) begin
          if (d == 8'h01 && latch_ready) latch_clock();
          latch_ready = (d == 8'h00);
        end else if (it.addr >= 16'hA000 && it.addr < 16'hC000) begin
          if (ram_mapped) begin
            if (cfg_ram_banks != 0) begin
              r.target = bmr_pkg::TGT_RAM_WR;
              r.mapped_addr = 21'({bank_ram, it.addr[12:0]});
              r.ram_wdata = d;
            end
          end else begin
            write_clock_reg(d);
          end
        end
      end
      bmr_pkg::CMD_TICK: begin
        if (!halted) tick_count = 17'((tick_count + 1) % DAY_SECONDS);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [7:0] wdata);
    bmr_pkg::item_t it;
    int             gap;
    it.cmd = cmd;
    it.addr = addr;
    it.wdata = wdata;
    @(negedge clk);
    if (!no_idle && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wdata, addr};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_access(it));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [2:0] value);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == bmr_pkg::REG_ROM_BANK_BITS) cfg_rom_bits = value;
    else cfg_ram_banks = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] rom_bits, input logic [2:0] ram_count);
    write_register(bmr_pkg::REG_ROM_BANK_BITS, rom_bits);
    write_register(bmr_pkg::REG_RAM_BANKS, ram_count);
  endtask

  task automatic test_rom_banking();
    send_item(bmr_pkg::CMD_READ, 16'h0000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h2000, 8'h00);
    send_item(bmr_pkg::CMD_READ, 16'h7FFF, 8'hFF);
    send_item(bmr_pkg::CMD_WRITE, 16'h3FFF, 8'hFF);
    send_item(bmr_pkg::CMD_READ, 16'h4000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h2000, 8'h80);
    send_item(bmr_pkg::CMD_READ, 16'h3FFF, 8'h00);
  endtask

  task automatic test_ram_window();
    send_item(bmr_pkg::CMD_READ, 16'hA000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h0000, bmr_pkg::RAM_ENABLE_KEY);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h03);
    send_item(bmr_pkg::CMD_WRITE, 16'hBFFF, 8'hA5);
    send_item(bmr_pkg::CMD_READ, 16'hBFFF, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h1FFF, 8'h55);
    send_item(bmr_pkg::CMD_WRITE, 16'h0000, 8'h00);
    send_item(bmr_pkg::CMD_READ, 16'hA123, 8'h00);
  endtask

  task automatic test_clock_regs();
    send_item(bmr_pkg::CMD_WRITE, 16'h0000, bmr_pkg::RAM_ENABLE_KEY);
    send_item(bmr_pkg::CMD_WRITE, 16'h5FFF, 8'h0A);
    send_item(bmr_pkg::CMD_WRITE, 16'hA000, 8'hFF);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h08);
    send_item(bmr_pkg::CMD_WRITE, 16'hB000, 8'h3C);
    send_item(bmr_pkg::CMD_TICK, 16'hFFFF, 8'hFF);
    send_item(bmr_pkg::CMD_WRITE, 16'h6000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h7FFF, 8'h01);
    send_item(bmr_pkg::CMD_READ, 16'hA000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h6000, 8'h01);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h0C);
    send_item(bmr_pkg::CMD_WRITE, 16'hA000, 8'hFF);
    send_item(bmr_pkg::CMD_TICK, 16'h0000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h6000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h6000, 8'h01);
    send_item(bmr_pkg::CMD_READ, 16'hA000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'hA000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h6000, 8'h02);
  endtask

  task automatic test_unmapped();
    send_item(bmr_pkg::CMD_READ, 16'h8000, 8'h00);
    send_item(bmr_pkg::CMD_READ, 16'h9FFF, 8'h00);
    send_item(bmr_pkg::CMD_READ, 16'hC000, 8'h00);
    send_item(bmr_pkg::CMD_READ, 16'hFFFF, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h8000, 8'hFF);
    send_item(CMD_UNUSED, 16'hFFFF, 8'hFF);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h04);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h0D);
  endtask

  task automatic test_no_ram();
    set_config(3'd1, 3'd0);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h00);
    send_item(bmr_pkg::CMD_READ, 16'hA000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'hA000, 8'h5A);
    send_item(bmr_pkg::CMD_WRITE, 16'h2000, 8'h02);
    send_item(bmr_pkg::CMD_READ, 16'h4001, 8'h00);
    set_config(3'd7, 3'd4);
  endtask

  // clock set to 23:59:59, a few ticks, then a latch folds past midnight
  task automatic test_day_wrap();
    no_idle = 1'b1;
    send_item(bmr_pkg::CMD_WRITE, 16'h0000, bmr_pkg::RAM_ENABLE_KEY);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h0C);
    send_item(bmr_pkg::CMD_WRITE, 16'hA000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h0A);
    send_item(bmr_pkg::CMD_WRITE, 16'hA000, 8'h17);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h09);
    send_item(bmr_pkg::CMD_WRITE, 16'hA000, 8'h3B);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h08);
    send_item(bmr_pkg::CMD_WRITE, 16'hA000, 8'h3B);
    repeat (5) send_item(bmr_pkg::CMD_TICK, 16'($urandom), 8'($urandom));
    send_item(bmr_pkg::CMD_WRITE, 16'h6000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h6000, 8'h01);
    send_item(bmr_pkg::CMD_READ, 16'hA000, 8'h00);
    send_item(bmr_pkg::CMD_WRITE, 16'h4000, 8'h0A);
    send_item(bmr_pkg::CMD_READ, 16'hA000, 8'h00);
    no_idle = 1'b0;
  endtask

  task automatic send_random_item();
    int          kind;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  sel;
    kind = $urandom_range(0, 99);
    a = 16'($urandom);
    d = 8'($urandom);
    sel = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(8, 12));
    if (kind < 20) begin
      send_item(bmr_pkg::CMD_READ, {1'b0, a[14:0]}, d);
    end else if (kind < 35) begin
      send_item(bmr_pkg::CMD_READ, {3'b101, a[12:0]}, d);
    end else if (kind < 45) begin
      send_item(bmr_pkg::CMD_WRITE, {3'b101, a[12:0]}, d);
    end else if (kind < 50) begin
      send_item(bmr_pkg::CMD_WRITE, {3'b000, a[12:0]},
                ($urandom_range(0, 3) == 0) ? d
                                            : (d[0] ? bmr_pkg::RAM_ENABLE_KEY : 8'h00));
    end else if (kind < 56) begin
      send_item(bmr_pkg::CMD_WRITE, {3'b001, a[12:0]}, d);
    end else if (kind < 64) begin
      send_item(bmr_pkg::CMD_WRITE, {3'b010, a[12:0]},
                ($urandom_range(0, 3) == 0) ? d : sel);
    end else if (kind < 70) begin
      send_item(bmr_pkg::CMD_WRITE, {3'b011, a[12:0]},
                ($urandom_range(0, 5) == 0) ? d : 8'h00);
      send_item(bmr_pkg::CMD_WRITE, {3'b011, 13'($urandom)},
                ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h01);
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 20))
        send_item(bmr_pkg::CMD_TICK, 16'($urandom), 8'($urandom));
    end else begin
      send_item(2'($urandom_range(0, 3)), a, d);
    end
  endtask

  task automatic test_random_traffic();
    logic [2:0] rom_bits [6] = '{3'd7, 3'd1, 3'd4, 3'd2, 3'd6, 3'd7};
    logic [2:0] ram_count [6] = '{3'd4, 3'd0, 3'd2, 3'd1, 3'd3, 3'd4};
    int         phase_end;
    for (int p = 0; p < 6; p++) begin
      set_config(rom_bits[p], ram_count[p]);
      phase_end = items_sent + 75;
      while (items_sent < phase_end) begin
        send_random_item();
        if (p == 2 && items_sent == phase_end - 40) drain_results();
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    if (no_idle || stall_mode == 0) m_axis_tready <= 1'b1;
    else if (stall_mode == 1) m_axis_tready <= 1'($urandom_range(0, 1));
    else m_axis_tready <= ($urandom_range(0, 7) == 0);
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bmr_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transaction: expected none, actual target 0x%0h",
                 $time, m_axis_tuser);
      end else begin
        want = expected_results.pop_front();
        check_field("target", want.target, m_axis_tuser);
        check_field("mapped_addr", want.mapped_addr, m_axis_tdata[20:0]);
        check_field("read_data", want.read_data, m_axis_tdata[28:21]);
        check_field("ram_wdata", want.ram_wdata, m_axis_tdata[36:29]);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    reset_mapper_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_config(3'd7, 3'd4);
    test_rom_banking();
    test_ram_window();
    test_clock_regs();
    test_unmapped();
    test_no_ram();
    test_day_wrap();
    test_random_traffic();
    drain_results();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: banked_mapper_with_rtc_unit.f
hw/rtl/bmr_pkg.sv
hw/rtl/bmr_cfg.sv
hw/rtl/bmr_rtc.sv
hw/rtl/bmr_core.sv
hw/rtl/banked_mapper_with_rtc_unit.sv
tb/sv/tb_banked_mapper_with_rtc_unit.sv
